@@ hdl/des_round_function_top_assert.svh @@
`ifndef DES_ROUND_FUNCTION_TOP_ASSERT_SVH
`define DES_ROUND_FUNCTION_TOP_ASSERT_SVH

// same-cycle implication, checked on rising clk outside reset
`define DRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// next-cycle implication, checked on rising clk outside reset
`define DRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error(msg);

`endif

@@ hdl/desrf_pkg.sv @@
package desrf_pkg;

  localparam int HalfW = 32;
  localparam int KeyW  = 48;
  localparam int NumSbox = 8;
  localparam int SboxDepth = 64;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [KeyW-1:0]  key_t;

  // 1-based positions, position 1 is the msb
  localparam logic [5:0] ETab [KeyW] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] PTab [HalfW] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] STab [NumSbox][SboxDepth] = '{
    '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
      4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
      4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
      4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
      4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
      4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
      4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13},
    '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
      4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
      4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
      4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
      4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
      4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
      4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
      4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9},
    '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
      4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
      4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
      4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
      4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
      4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
      4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
      4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12},
    '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
      4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
      4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
      4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
      4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
      4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
      4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
      4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14},
    '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
      4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
      4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
      4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
      4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
      4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
      4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
      4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3},
    '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
      4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
      4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
      4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
      4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
      4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
      4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
      4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13},
    '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
      4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
      4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
      4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
      4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
      4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
      4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
      4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12},
    '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
      4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
      4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
      4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
      4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
      4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
      4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
      4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11}
  };

  function automatic key_t expand(input half_t half);
    key_t wide;
    logic [4:0] src;
    for (int k = 0; k < KeyW; k++) begin
      src = 5'(6'd32 - ETab[k]);
      wide[KeyW-1-k] = half[src];
    end
    return wide;
  endfunction

  function automatic half_t substitute(input key_t mixed);
    half_t word;
    logic [5:0] six;
    for (int g = 0; g < NumSbox; g++) begin
      six = mixed[KeyW-1-6*g -: 6];
      word[HalfW-1-4*g -: 4] = STab[g][{six[5], six[0], six[4:1]}];
    end
    return word;
  endfunction

  function automatic half_t permute(input half_t word);
    half_t res;
    logic [4:0] src;
    for (int k = 0; k < HalfW; k++) begin
      src = 5'(6'd32 - PTab[k]);
      res[HalfW-1-k] = word[src];
    end
    return res;
  endfunction

endpackage

@@ hdl/desrf_mix.sv @@
module desrf_mix
  import desrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  half_t half_i,
  input  key_t  key_i,
  output logic  vld_o,
  output key_t  mixed_o
);

  logic vld_r;
  key_t mixed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    mixed_r <= expand(half_i) ^ key_i;
  end

  assign vld_o   = vld_r;
  assign mixed_o = mixed_r;

endmodule

@@ hdl/desrf_sbox.sv @@
module desrf_sbox
  import desrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  key_t  mixed_i,
  output logic  vld_o,
  output half_t word_o
);

  logic  vld_r;
  half_t word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= substitute(mixed_i);
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;

endmodule

@@ hdl/desrf_perm.sv @@
module desrf_perm
  import desrf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  half_t word_i,
  output logic  vld_o,
  output half_t res_o
);

  logic  vld_r;
  half_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= permute(word_i);
  end

  assign vld_o = vld_r;
  assign res_o = res_r;

endmodule

@@ hdl/des_round_function_top.sv @@
// channel  | ports                             | handshake
// ---------+-----------------------------------+----------------------------------
// input    | in_right_half, in_round_key       | start high while busy low
// result   | out_f_result                      | out_valid strobe, one cycle
//
// Three register stages: expand and key mix, S-box lookup, P permutation.
// An item may start in every cycle with busy low; result strobes from P register.
// busy is high only during reset and the cycle after; the pipeline never stalls.
// Reset is synchronous, active low, and drops all items in flight.
`include "des_round_function_top_assert.svh"

module des_round_function_top
  import desrf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [HalfW-1:0]    in_right_half,
  input  logic [KeyW-1:0]     in_round_key,
  output logic                out_valid,
  output logic [HalfW-1:0]    out_f_result
);

  logic  busy_r;
  logic  busy_nxt;
  logic  accept;
  logic  s1_vld;
  key_t  s1_mixed;
  logic  s2_vld;
  half_t s2_word;

  assign busy_nxt = 1'b0;
  assign accept   = start && !busy_r;
  assign busy     = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  desrf_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (accept),
    .half_i  (in_right_half),
    .key_i   (in_round_key),
    .vld_o   (s1_vld),
    .mixed_o (s1_mixed)
  );

  desrf_sbox u_sbox (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (s1_vld),
    .mixed_i (s1_mixed),
    .vld_o   (s2_vld),
    .word_o  (s2_word)
  );

  desrf_perm u_perm (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (s2_vld),
    .word_i (s2_word),
    .vld_o  (out_valid),
    .res_o  (out_f_result)
  );

  `DRF_ASSERT_IMP(a_accept_to_out, accept, ##3 out_valid, "accepted item missing at output")
  `DRF_ASSERT_IMP(a_out_has_src, out_valid, $past(accept, 3), "result without accepted item")
  `DRF_ASSERT_NXT(a_s1_to_s2, s1_vld, s2_vld, "item lost between mix and sbox")

endmodule
